>>> rtl/core/assert_macros.svh
// Assertion macros shared by the compensation block.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clk edge, disabled while reset is active.
`define AST_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen.
`define AST_NEVER(lbl, cond, msg) `AST_PROP(lbl, !(cond), msg)
`endif

>>> rtl/core/ptc_pkg.sv
// Shared types and register codes for the compensation block.
// No dependencies.
package ptc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TEMP_CAL  = 3'd0;
    localparam logic [2:0] CFG_PRESS_A   = 3'd1;
    localparam logic [2:0] CFG_PRESS_B   = 3'd2;
    localparam logic [2:0] CFG_PRESS_P9  = 3'd3;
    localparam logic [2:0] CFG_HUM_CAL   = 3'd4;
    localparam logic [2:0] CFG_HUM_EN    = 3'd5;

    // Results that ride alongside the pressure divider.
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [16:0] hum;
    } side_t;

    // State handed from one divider cell to the next.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        logic        neg;
        logic        dz;
        side_t       side;
    } div_t;

    // Sideband after the divider.
    typedef struct packed {
        side_t side;
        logic  dz;
    } post_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [31:0] press;
        logic [16:0] hum;
        logic        dz;
    } res_t;

endpackage

>>> rtl/core/ptc_mul64.sv
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product.
// Built from three 32 by 32 partial products; no package dependency.
module ptc_mul64
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_w;
    logic [31:0] lh_w;
    logic [31:0] hl_w;
    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;

    assign ll_w = a[31:0] * b[31:0];
    assign lh_w = a[31:0] * b[63:32];
    assign hl_w = a[63:32] * b[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_w;
            lh_reg <= lh_w;
            hl_reg <= hl_w;
            p_reg  <= ll_reg + {lh_reg + hl_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/core/ptc_div_cell.sv
// One restoring-division step of the pressure divider chain.
// Depends on ptc_pkg for the div_t cell state.
module ptc_div_cell
    import ptc_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  div_t d_in,
    output div_t d_out
);

    logic [64:0] trial_w;
    logic [64:0] diff_w;
    logic        take_w;
    div_t        st_next;
    div_t        st_reg;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial_w = {d_in.rem, d_in.num[63]};
    assign diff_w  = trial_w - {1'b0, d_in.den};
    assign take_w  = (trial_w >= {1'b0, d_in.den});

    always_comb
    begin
        st_next     = d_in;
        st_next.rem = take_w ? diff_w[63:0] : trial_w[63:0];
        st_next.num = {d_in.num[62:0], take_w};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign d_out = st_reg;

endmodule

>>> rtl/core/pressure_temp_humidity_compensation.sv
// Top level of the pressure, temperature and humidity compensation block.
// Depends on ptc_pkg, ptc_mul64, ptc_div_cell and assert_macros.svh.
`include "assert_macros.svh"

// A new reading is taken every clock cycle while the output buffer has room.
// Most of the pipeline is the row of 64 divider cells, one quotient bit per
// cell, that form the signed 64-bit pressure division; the rest are the
// registered arithmetic levels and 64-bit multiplier stages. A two-entry
// output buffer lets the block keep accepting readings while one result
// waits; only when both entries are held does s_tready drop and the whole
// pipeline freeze. Calibration writes are taken at any time on the cfg
// channel and should be made while no reading is in flight.
module pressure_temp_humidity_compensation
    import ptc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // raw_temperature, raw_pressure, raw_humidity
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // temperature_centi, fine_temperature,
                                    // pressure_q24_8, humidity_q7_10, zero pad
    output logic         m_tuser,   // divisor_zero
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam logic [63:0] PRESS_FINE_OFFSET = 64'd128000;
    localparam logic [20:0] PRESS_BASE        = 21'd1048576;
    localparam logic [63:0] PRESS_SCALE       = 64'd3125;
    localparam logic [63:0] PRESS_HALF        = 64'h0000_8000_0000_0000;
    localparam logic [31:0] HUM_FINE_OFFSET   = 32'd76800;
    localparam logic [31:0] HUM_CLAMP_MAX     = 32'd419430400;
    localparam logic [31:0] HUM_ROUND_A       = 32'd16384;
    localparam logic [31:0] HUM_OFFSET_B      = 32'd2097152;
    localparam logic [31:0] HUM_ROUND_B       = 32'd8192;
    localparam logic [31:0] HUM_OFFSET_C      = 32'd32768;
    localparam int          DIV_CELLS         = 64;

    // Configuration registers.
    logic [47:0] tc_reg;
    logic [63:0] pa_reg;
    logic [63:0] pb_reg;
    logic [15:0] p9_reg;
    logic [63:0] hc_reg;
    logic        hen_reg;

    // Flow control.
    logic        pipe_en;
    logic        vld_reg [1:84];
    res_t        buf_reg [0:1];
    logic [1:0]  cnt_reg;
    logic        push_w;
    logic        pop_w;
    res_t        res_w;

    // Calibration fields.
    logic [31:0] t1_w, t2_w, t3_w;
    logic [31:0] h1_w, h2_w, h3_w, h5_w, h6_w;
    logic [11:0] h4_w;
    logic [63:0] p1_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;

    // Temperature path.
    logic [19:0] adc_t_w;
    logic [31:0] ta_w, td_w;
    logic [31:0] ma_reg, dd_reg, v1_reg, m3t_reg;
    logic [31:0] dds_w, m3s_w, f3_w, temp_w;
    logic [31:0] fine_d [3:9];
    logic [31:0] temp_d [4:9];
    logic [19:0] adcp_d [1:9];
    logic [15:0] adch_d [1:4];

    // Humidity path.
    logic [31:0] hv_w;
    logic [31:0] hm5_reg, hm6_reg, hm3_reg;
    logic [31:0] lhs_pre_w, lhs_reg, lhs6_reg, hmi_reg, hmr_reg;
    logic [31:0] hm6s_w, hm3s_w, hmis_w, rhs_w;
    logic [31:0] w7_reg, w8_reg, w9_reg, ss_reg, mh_reg;
    logic [31:0] s_w, sss_w, mh4_w, w2_w, wc_w;
    logic [16:0] hum_w;
    side_t       side_d [10:12];

    // Pressure path.
    logic [63:0] xs_reg;
    logic [63:0] sq_w, xp5_w, xp2_w, sqp6_w, sqp3_w, sqp3s_w;
    logic [63:0] xp5_d [7:8];
    logic [63:0] xp2_d [7:8];
    logic [63:0] x2_reg, xa1_reg, nb_reg, xb_reg;
    logic [63:0] xp1_w, num_w;
    logic [20:0] pd_w;
    div_t        chain_w [0:DIV_CELLS];
    div_t        div_in_reg;
    logic [63:0] q_d [78:82];
    post_t       post_d [78:84];
    logic [63:0] y2_d [81:82];
    logic [63:0] ps78_w, ps80_w, p9ps_w, y2raw_w, y1raw_w, y1s_w, y2s_w;
    logic [63:0] sum_reg, press_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg  <= '0;
            pa_reg  <= '0;
            pb_reg  <= '0;
            p9_reg  <= '0;
            hc_reg  <= '0;
            hen_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEMP_CAL: tc_reg  <= cfg_data[47:0];
                CFG_PRESS_A:  pa_reg  <= cfg_data;
                CFG_PRESS_B:  pb_reg  <= cfg_data;
                CFG_PRESS_P9: p9_reg  <= cfg_data[15:0];
                CFG_HUM_CAL:  hc_reg  <= cfg_data;
                CFG_HUM_EN:   hen_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign t1_w = {16'd0, tc_reg[15:0]};
    assign t2_w = {{16{tc_reg[31]}}, tc_reg[31:16]};
    assign t3_w = {{16{tc_reg[47]}}, tc_reg[47:32]};

    assign p1_w = {48'd0, pa_reg[15:0]};
    assign p2_w = {{48{pa_reg[31]}}, pa_reg[31:16]};
    assign p3_w = {{48{pa_reg[47]}}, pa_reg[47:32]};
    assign p4_w = {{48{pa_reg[63]}}, pa_reg[63:48]};
    assign p5_w = {{48{pb_reg[15]}}, pb_reg[15:0]};
    assign p6_w = {{48{pb_reg[31]}}, pb_reg[31:16]};
    assign p7_w = {{48{pb_reg[47]}}, pb_reg[47:32]};
    assign p8_w = {{48{pb_reg[63]}}, pb_reg[63:48]};
    assign p9_w = {{48{p9_reg[15]}}, p9_reg};

    assign h1_w = {24'd0, hc_reg[7:0]};
    assign h2_w = {{16{hc_reg[23]}}, hc_reg[23:8]};
    assign h3_w = {24'd0, hc_reg[31:24]};
    assign h4_w = hc_reg[43:32];
    assign h5_w = {{20{hc_reg[55]}}, hc_reg[55:44]};
    assign h6_w = {{24{hc_reg[63]}}, hc_reg[63:56]};

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves as one while the output buffer
    // has room.
    // ------------------------------------------------------------------
    assign pipe_en  = (cnt_reg != 2'd2);
    assign s_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 84; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= 84; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Temperature, humidity and pressure arithmetic, level by level
    // ------------------------------------------------------------------
    assign adc_t_w = s_tdata[19:0];
    assign ta_w    = {15'd0, adc_t_w[19:3]} - {15'd0, t1_w[15:0], 1'b0};
    assign td_w    = {16'd0, adc_t_w[19:4]} - t1_w;

    assign dds_w   = $signed(dd_reg) >>> 12;
    assign m3s_w   = $signed(m3t_reg) >>> 14;
    assign f3_w    = fine_d[3];
    assign temp_w  = $signed(f3_w + {f3_w[29:0], 2'b00} + 32'd128) >>> 8;
    assign hv_w    = f3_w - HUM_FINE_OFFSET;

    assign lhs_pre_w = {2'b00, adch_d[4], 14'd0} - {h4_w, 20'd0} - hm5_reg + HUM_ROUND_A;
    assign hm6s_w    = $signed(hm6_reg) >>> 10;
    assign hm3s_w    = $signed(hm3_reg) >>> 11;
    assign hmis_w    = $signed(hmi_reg) >>> 10;
    assign rhs_w     = $signed(hmr_reg + HUM_ROUND_B) >>> 14;
    assign s_w       = $signed(w7_reg) >>> 15;
    assign sss_w     = $signed(ss_reg) >>> 7;
    // The shifts stand alone so that they stay arithmetic.
    assign mh4_w     = $signed(mh_reg) >>> 4;
    assign w2_w      = w9_reg - mh4_w;

    always_comb
    begin
        if (w2_w[31])
        begin
            wc_w = 32'd0;
        end
        else if (w2_w > HUM_CLAMP_MAX)
        begin
            wc_w = HUM_CLAMP_MAX;
        end
        else
        begin
            wc_w = w2_w;
        end
        hum_w = hen_reg ? wc_w[28:12] : 17'd0;
    end

    // Pressure intermediate terms.
    assign pd_w    = PRESS_BASE - {1'b0, adcp_d[9]};
    assign sqp3s_w = $signed(sqp3_w) >>> 8;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            // level 1
            ma_reg    <= ta_w * t2_w;
            dd_reg    <= td_w * td_w;
            adcp_d[1] <= s_tdata[39:20];
            adch_d[1] <= s_tdata[55:40];
            for (int k = 2; k <= 9; k++)
            begin
                adcp_d[k] <= adcp_d[k-1];
            end
            for (int k = 2; k <= 4; k++)
            begin
                adch_d[k] <= adch_d[k-1];
            end
            // level 2
            v1_reg    <= $signed(ma_reg) >>> 11;
            m3t_reg   <= dds_w * t3_w;
            // level 3
            fine_d[3] <= v1_reg + m3s_w;
            for (int k = 4; k <= 9; k++)
            begin
                fine_d[k] <= fine_d[k-1];
            end
            // level 4
            temp_d[4] <= temp_w;
            for (int k = 5; k <= 9; k++)
            begin
                temp_d[k] <= temp_d[k-1];
            end
            xs_reg    <= {{32{f3_w[31]}}, f3_w} - PRESS_FINE_OFFSET;
            hm5_reg   <= hv_w * h5_w;
            hm6_reg   <= hv_w * h6_w;
            hm3_reg   <= hv_w * h3_w;
            // level 5
            lhs_reg   <= $signed(lhs_pre_w) >>> 15;
            hmi_reg   <= hm6s_w * (hm3s_w + HUM_OFFSET_C);
            // level 6
            lhs6_reg  <= lhs_reg;
            hmr_reg   <= (hmis_w + HUM_OFFSET_B) * h2_w;
            // level 7
            w7_reg    <= lhs6_reg * rhs_w;
            xp5_d[7]  <= xp5_w;
            xp2_d[7]  <= xp2_w;
            // level 8
            w8_reg    <= w7_reg;
            ss_reg    <= s_w * s_w;
            xp5_d[8]  <= xp5_d[7];
            xp2_d[8]  <= xp2_d[7];
            // level 9
            w9_reg    <= w8_reg;
            mh_reg    <= sss_w * h1_w;
            x2_reg    <= sqp6_w + (xp5_d[8] << 17) + (p4_w << 35);
            xa1_reg   <= PRESS_HALF + sqp3s_w + (xp2_d[8] << 12);
            // level 10
            side_d[10] <= '{temp: temp_d[9], fine: fine_d[9], hum: hum_w};
            side_d[11] <= side_d[10];
            side_d[12] <= side_d[11];
            nb_reg    <= {12'd0, pd_w, 31'd0} - x2_reg;
            // level 12
            xb_reg    <= $signed(xp1_w) >>> 33;
            // level 13: magnitudes into the divider
            div_in_reg.rem  <= '0;
            div_in_reg.num  <= num_w[63] ? (64'd0 - num_w) : num_w;
            div_in_reg.den  <= xb_reg[63] ? (64'd0 - xb_reg) : xb_reg;
            div_in_reg.neg  <= num_w[63] ^ xb_reg[63];
            div_in_reg.dz   <= (xb_reg == 64'd0);
            div_in_reg.side <= side_d[12];
            // level 78: restore the quotient sign
            q_d[78]   <= chain_w[DIV_CELLS].neg ? (64'd0 - chain_w[DIV_CELLS].num)
                                                : chain_w[DIV_CELLS].num;
            post_d[78] <= '{side: chain_w[DIV_CELLS].side, dz: chain_w[DIV_CELLS].dz};
            for (int k = 79; k <= 82; k++)
            begin
                q_d[k] <= q_d[k-1];
            end
            for (int k = 79; k <= 84; k++)
            begin
                post_d[k] <= post_d[k-1];
            end
            y2_d[81]  <= y2raw_w;
            y2_d[82]  <= y2_d[81];
            // level 83 and 84
            sum_reg   <= q_d[82] + y1s_w + y2s_w;
            press_reg <= ($signed(sum_reg) >>> 8) + (p7_w << 4);
        end
    end

    // ------------------------------------------------------------------
    // 64-bit products, two levels each
    // ------------------------------------------------------------------
    ptc_mul64 u_mul_sq  (.clk(clk), .en(pipe_en), .a(xs_reg),  .b(xs_reg),      .p(sq_w));
    ptc_mul64 u_mul_p5  (.clk(clk), .en(pipe_en), .a(xs_reg),  .b(p5_w),        .p(xp5_w));
    ptc_mul64 u_mul_p2  (.clk(clk), .en(pipe_en), .a(xs_reg),  .b(p2_w),        .p(xp2_w));
    ptc_mul64 u_mul_p6  (.clk(clk), .en(pipe_en), .a(sq_w),    .b(p6_w),        .p(sqp6_w));
    ptc_mul64 u_mul_p3  (.clk(clk), .en(pipe_en), .a(sq_w),    .b(p3_w),        .p(sqp3_w));
    ptc_mul64 u_mul_p1  (.clk(clk), .en(pipe_en), .a(xa1_reg), .b(p1_w),        .p(xp1_w));
    ptc_mul64 u_mul_sc  (.clk(clk), .en(pipe_en), .a(nb_reg),  .b(PRESS_SCALE), .p(num_w));

    assign ps78_w = $signed(q_d[78]) >>> 13;
    assign ps80_w = $signed(q_d[80]) >>> 13;
    assign y1s_w  = $signed(y1raw_w) >>> 25;
    assign y2s_w  = $signed(y2_d[82]) >>> 19;

    ptc_mul64 u_mul_p9  (.clk(clk), .en(pipe_en), .a(p9_w),   .b(ps78_w),  .p(p9ps_w));
    ptc_mul64 u_mul_p8  (.clk(clk), .en(pipe_en), .a(p8_w),   .b(q_d[78]), .p(y2raw_w));
    ptc_mul64 u_mul_y1  (.clk(clk), .en(pipe_en), .a(p9ps_w), .b(ps80_w),  .p(y1raw_w));

    // ------------------------------------------------------------------
    // Divider: one quotient bit per cell
    // ------------------------------------------------------------------
    assign chain_w[0] = div_in_reg;

    for (genvar g = 0; g < DIV_CELLS; g++)
    begin : g_div
        ptc_div_cell u_cell
        (
            .clk   (clk),
            .en    (pipe_en),
            .d_in  (chain_w[g]),
            .d_out (chain_w[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output buffer, two entries, head at entry 0
    // ------------------------------------------------------------------
    assign res_w.temp  = post_d[84].side.temp;
    assign res_w.fine  = post_d[84].side.fine;
    assign res_w.press = post_d[84].dz ? 32'd0 : press_reg[31:0];
    assign res_w.hum   = post_d[84].side.hum;
    assign res_w.dz    = post_d[84].dz;

    assign push_w = pipe_en && vld_reg[84];
    assign pop_w  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, push_w} - {1'b0, pop_w};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_w)
        begin
            buf_reg[0] <= (push_w && (cnt_reg == 2'd1)) ? res_w : buf_reg[1];
        end
        else if (push_w)
        begin
            if (cnt_reg == 2'd0)
            begin
                buf_reg[0] <= res_w;
            end
            else
            begin
                buf_reg[1] <= res_w;
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {7'd0, buf_reg[0].hum, buf_reg[0].press, buf_reg[0].fine,
                       buf_reg[0].temp};
    assign m_tuser  = buf_reg[0].dz;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `AST_PROP(a_dz_press_zero, (m_tvalid && m_tuser) |-> (m_tdata[95:64] == 32'd0), "dz press")
    `AST_NEVER(a_hum_range, m_tvalid && (m_tdata[112:96] > 17'd102400), "humidity above clamp")
    `AST_PROP(a_stall_hold, !pipe_en |=> $stable(vld_reg[84]), "last stage moved in stall")

endmodule
